/* hw/rtl/rwlm_pkg.sv */
package rwlm_pkg;

   localparam int REQUESTERS  = 16;
   localparam int QUEUE_SLOTS = 16;
   localparam int QADDR_W     = $clog2(QUEUE_SLOTS);

   localparam logic [1:0] OP_ACQUIRE  = 2'd0;
   localparam logic [1:0] OP_RELEASE  = 2'd1;
   localparam logic [1:0] OP_ESCALATE = 2'd2;
   localparam logic [1:0] OP_CANCEL   = 2'd3;

   localparam logic [1:0] LATCH_FREE      = 2'd0;
   localparam logic [1:0] LATCH_SHARED    = 2'd1;
   localparam logic [1:0] LATCH_EXCLUSIVE = 2'd2;

   localparam logic [3:0] ST_GRANTED      = 4'd0;
   localparam logic [3:0] ST_QUEUED       = 4'd1;
   localparam logic [3:0] ST_REFUSED      = 4'd2;
   localparam logic [3:0] ST_CANCELLED    = 4'd3;
   localparam logic [3:0] ST_ALREADY_WOKE = 4'd4;
   localparam logic [3:0] ST_ESCALATED    = 4'd5;
   localparam logic [3:0] ST_ESC_REFUSED  = 4'd6;
   localparam logic [3:0] ST_RELEASED     = 4'd7;
   localparam logic [3:0] ST_ERROR        = 4'd8;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_WAKEUP = 1'b1;

   localparam logic [4:0] SHARED_LIMIT_RESET = 5'd4;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] requester;
      logic       mode;
      logic       high_priority;
      logic       try_only;
      logic [7:0] attempt;
      logic [7:0] retry_limit;
      logic       unlimited_retries;
      logic [4:0] exclusive_wakeup_limit;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  who;
      logic [3:0]  status;
      logic [1:0]  latch_mode;
      logic [15:0] holders;
      logic [4:0]  waiters;
      logic [63:0] exclusive_sequence;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       mode;
      logic [3:0] id;
   } qentry_type;

endpackage

/* hw/rtl/reader_writer_latch_manager.sv */
// Shared/exclusive latch with a 16-deep wait queue kept in a one-port-read
// synchronous memory. A request is taken when start is high and busy is low;
// busy stays high until every result of that request has been shown. Each
// result is on rsp_data for one cycle with rsp_valid high and cannot be held
// off. Acquire that needs no queue lookup, escalate and release without
// wakeups go from S_DECIDE straight to S_STATUS to show the status result.
// Queueing an acquire and cancel walk the queue one entry at a time, a memory
// read in S_RD and a compare in S_CHK; cancel then compacts the queue, moving
// each entry with S_SHIFT_RD and S_SHIFT_WR. A release that wakes waiters
// scans each woken waiter through S_RD and S_CHK, plus one more entry when
// the run ends on an entry of the other mode, shows the status, then gives
// each wakeup result through S_WAKE_RD and S_WAKE_OUT. The longest
// request is a release that wakes sixteen waiters. No clearing pass is
// needed after reset.
module reader_writer_latch_manager
   import rwlm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECIDE   = 4'd1;
   localparam logic [3:0] S_RD       = 4'd2;
   localparam logic [3:0] S_CHK      = 4'd3;
   localparam logic [3:0] S_SHIFT_RD = 4'd4;
   localparam logic [3:0] S_SHIFT_WR = 4'd5;
   localparam logic [3:0] S_STATUS   = 4'd6;
   localparam logic [3:0] S_WAKE_RD  = 4'd7;
   localparam logic [3:0] S_WAKE_OUT = 4'd8;

   localparam logic [4:0] SLOTS5 = 5'(QUEUE_SLOTS);

   logic [3:0]   state_ff, state_in;
   req_type      req_ff, req_in;
   logic [4:0]   swl_ff, swl_in;
   logic [1:0]   latch_ff, latch_in;
   logic [15:0]  hold_ff, hold_in;
   logic [3:0]   owner_ff, owner_in;
   logic         ownv_ff, ownv_in;
   logic [63:0]  seq_ff, seq_in;
   logic [QADDR_W-1:0] head_ff, head_in;
   logic [4:0]   len_ff, len_in;
   logic [4:0]   idx_ff, idx_in;
   logic [4:0]   nw_ff, nw_in;
   logic [4:0]   cap_ff, cap_in;
   logic         hm_ff, hm_in;
   logic [QADDR_W-1:0] wbase_ff, wbase_in;
   logic [3:0]   status_ff, status_in;

   qentry_type   mem [QUEUE_SLOTS];
   qentry_type   rd_data_ff;
   logic         mem_we;
   logic [QADDR_W-1:0] mem_waddr, mem_raddr;
   qentry_type   mem_wdata;

   logic         id_ok, grant_ok, hm_match;
   logic [4:0]   idx_next, nw_next, cap_raw;
   qentry_type   new_entry;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         swl_ff    <= SHARED_LIMIT_RESET;
         latch_ff  <= LATCH_FREE;
         hold_ff   <= '0;
         owner_ff  <= '0;
         ownv_ff   <= 1'b0;
         seq_ff    <= '0;
         head_ff   <= '0;
         len_ff    <= '0;
         idx_ff    <= '0;
         nw_ff     <= '0;
         cap_ff    <= '0;
         hm_ff     <= 1'b0;
         wbase_ff  <= '0;
         status_ff <= ST_ERROR;
      end else begin
         state_ff  <= state_in;
         swl_ff    <= swl_in;
         latch_ff  <= latch_in;
         hold_ff   <= hold_in;
         owner_ff  <= owner_in;
         ownv_ff   <= ownv_in;
         seq_ff    <= seq_in;
         head_ff   <= head_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         nw_ff     <= nw_in;
         cap_ff    <= cap_in;
         hm_ff     <= hm_in;
         wbase_ff  <= wbase_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign id_ok     = (32'(req_ff.requester) < REQUESTERS);
   assign new_entry = '{mode: req_ff.mode, id: req_ff.requester};
   assign idx_next  = idx_ff + 5'd1;
   assign nw_next   = nw_ff + 5'd1;
   assign hm_match  = (idx_ff == 5'd0) || (rd_data_ff.mode == hm_ff);
   assign cap_raw   = rd_data_ff.mode ? req_ff.exclusive_wakeup_limit : swl_ff;

   always_comb begin
      if (req_ff.mode) begin
         grant_ok = (latch_ff == LATCH_FREE) ||
                    (latch_ff == LATCH_EXCLUSIVE && ownv_ff && owner_ff == req_ff.requester);
      end else begin
         grant_ok = (latch_ff == LATCH_FREE) || (latch_ff == LATCH_SHARED);
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      swl_in    = csr_wr_en ? csr_wr_data : swl_ff;
      latch_in  = latch_ff;
      hold_in   = hold_ff;
      owner_in  = owner_ff;
      ownv_in   = ownv_ff;
      seq_in    = seq_ff;
      head_in   = head_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      nw_in     = nw_ff;
      cap_in    = cap_ff;
      hm_in     = hm_ff;
      wbase_in  = wbase_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = head_ff;
      mem_wdata = new_entry;
      mem_raddr = head_ff + idx_ff[QADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            nw_in     = '0;
            idx_in    = '0;
            wbase_in  = head_ff;
            status_in = ST_ERROR;
            state_in  = S_STATUS;
            if (id_ok) begin
               unique case (req_ff.operation)
                  OP_ACQUIRE: begin
                     if (grant_ok) begin
                        if (hold_ff != 16'hFFFF) begin
                           if (!req_ff.mode) begin
                              latch_in = LATCH_SHARED;
                           end else if (latch_ff == LATCH_FREE) begin
                              latch_in = LATCH_EXCLUSIVE;
                              seq_in   = seq_ff + 64'd1;
                              owner_in = req_ff.requester;
                              ownv_in  = 1'b1;
                           end
                           hold_in   = hold_ff + 16'd1;
                           status_in = ST_GRANTED;
                        end
                     end else if ((!req_ff.unlimited_retries &&
                                   req_ff.attempt >= req_ff.retry_limit) ||
                                  req_ff.try_only) begin
                        status_in = ST_REFUSED;
                     end else if (len_ff >= SLOTS5) begin
                        status_in = ST_ERROR;
                     end else if (len_ff == 5'd0) begin
                        mem_we    = 1'b1;
                        mem_waddr = head_ff;
                        len_in    = 5'd1;
                        status_in = ST_QUEUED;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  OP_RELEASE: begin
                     if (hold_ff != 16'd0 && latch_ff != LATCH_FREE) begin
                        hold_in   = hold_ff - 16'd1;
                        status_in = ST_RELEASED;
                        if (hold_ff == 16'd1) begin
                           if (latch_ff == LATCH_EXCLUSIVE) begin
                              seq_in   = seq_ff + 64'd1;
                              ownv_in  = 1'b0;
                              owner_in = '0;
                           end
                           latch_in = LATCH_FREE;
                           if (len_ff != 5'd0) begin
                              state_in = S_RD;
                           end
                        end
                     end
                  end
                  OP_ESCALATE: begin
                     if (latch_ff == LATCH_SHARED) begin
                        if (hold_ff == 16'd1) begin
                           latch_in  = LATCH_EXCLUSIVE;
                           owner_in  = req_ff.requester;
                           ownv_in   = 1'b1;
                           seq_in    = seq_ff + 64'd1;
                           status_in = ST_ESCALATED;
                        end else begin
                           status_in = ST_ESC_REFUSED;
                        end
                     end else if (latch_ff == LATCH_EXCLUSIVE) begin
                        status_in = (!ownv_ff || owner_ff == req_ff.requester) ?
                                    ST_ESCALATED : ST_ESC_REFUSED;
                     end
                  end
                  OP_CANCEL: begin
                     if (len_ff == 5'd0) begin
                        status_in = ST_ALREADY_WOKE;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: status_in = ST_ERROR;
               endcase
            end
         end

         S_RD: begin
            state_in = S_CHK;
         end

         S_CHK: begin
            unique case (req_ff.operation)
               OP_ACQUIRE: begin
                  if (rd_data_ff.id == req_ff.requester) begin
                     status_in = ST_ERROR;
                     state_in  = S_STATUS;
                  end else if (idx_next == len_ff) begin
                     // not queued yet: insert at head or tail
                     mem_we    = 1'b1;
                     mem_waddr = req_ff.high_priority ?
                                 head_ff - QADDR_W'(1) : head_ff + len_ff[QADDR_W-1:0];
                     if (req_ff.high_priority) begin
                        head_in = head_ff - QADDR_W'(1);
                     end
                     len_in    = len_ff + 5'd1;
                     status_in = ST_QUEUED;
                     state_in  = S_STATUS;
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_RD;
                  end
               end
               OP_RELEASE: begin
                  if (idx_ff == 5'd0) begin
                     hm_in  = rd_data_ff.mode;
                     cap_in = (cap_raw == 5'd0) ? 5'd1 : cap_raw;
                  end
                  if (hm_match) begin
                     nw_in  = nw_next;
                     idx_in = idx_next;
                     if (idx_next == len_ff ||
                         nw_next >= ((idx_ff == 5'd0) ?
                                     ((cap_raw == 5'd0) ? 5'd1 : cap_raw) : cap_ff)) begin
                        head_in  = head_ff + nw_next[QADDR_W-1:0];
                        len_in   = len_ff - nw_next;
                        state_in = S_STATUS;
                     end else begin
                        state_in = S_RD;
                     end
                  end else begin
                     head_in  = head_ff + nw_ff[QADDR_W-1:0];
                     len_in   = len_ff - nw_ff;
                     state_in = S_STATUS;
                  end
               end
               default: begin
                  if (rd_data_ff.id == req_ff.requester) begin
                     status_in = ST_CANCELLED;
                     if (idx_next == len_ff) begin
                        len_in   = len_ff - 5'd1;
                        state_in = S_STATUS;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end else if (idx_next == len_ff) begin
                     status_in = ST_ALREADY_WOKE;
                     state_in  = S_STATUS;
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_RD;
                  end
               end
            endcase
         end

         S_SHIFT_RD: begin
            // fetch the entry behind the gap
            mem_raddr = head_ff + idx_next[QADDR_W-1:0];
            state_in  = S_SHIFT_WR;
         end

         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = head_ff + idx_ff[QADDR_W-1:0];
            mem_wdata = rd_data_ff;
            idx_in    = idx_next;
            if (idx_next + 5'd1 == len_ff) begin
               len_in   = len_ff - 5'd1;
               state_in = S_STATUS;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end

         S_STATUS: begin
            idx_in   = '0;
            state_in = (nw_ff != 5'd0) ? S_WAKE_RD : S_IDLE;
         end

         S_WAKE_RD: begin
            mem_raddr = wbase_ff + idx_ff[QADDR_W-1:0];
            state_in  = S_WAKE_OUT;
         end

         S_WAKE_OUT: begin
            idx_in   = idx_next;
            state_in = (idx_next == nw_ff) ? S_IDLE : S_WAKE_RD;
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_STATUS) || (state_ff == S_WAKE_OUT);

   always_comb begin
      rsp_data.latch_mode         = latch_ff;
      rsp_data.holders            = hold_ff;
      rsp_data.waiters            = len_ff;
      rsp_data.exclusive_sequence = seq_ff;
      if (state_ff == S_WAKE_OUT) begin
         rsp_data.kind   = KIND_WAKEUP;
         rsp_data.who    = rd_data_ff.id;
         rsp_data.status = ST_GRANTED;
         rsp_data.last   = (idx_next == nw_ff);
      end else begin
         rsp_data.kind   = KIND_STATUS;
         rsp_data.who    = req_ff.requester;
         rsp_data.status = status_ff;
         rsp_data.last   = (nw_ff == 5'd0);
      end
   end

endmodule

/* hw/rtl/rwlm_checker.sv */
module rwlm_checker
   import rwlm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // a taken request always raises busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid && !busy)
      else $error("activity after final result");

   a_wake_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_WAKEUP |-> rsp_data.status == ST_GRANTED
         && rsp_data.latch_mode == LATCH_FREE)
      else $error("wakeup result malformed");

endmodule

bind reader_writer_latch_manager rwlm_checker u_rwlm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
